// File: design/htc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, register indexes and controller/datapath interface types
// for the hysteresis thermostat controller. No dependencies.

package htc_pkg;

   localparam int HISTORY_DEPTH = 5;

   localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
   localparam int COUNT_W = $clog2(HISTORY_DEPTH + 1);

   localparam int TEMP_MIN = -4000;
   localparam int TEMP_MAX = 12500;
   localparam int HUM_MIN  = 0;
   localparam int HUM_MAX  = 10000;

   localparam int TEMP_W = 15;
   localparam int HUM_W  = 14;
   localparam int IN_W   = 16;

   // sums over the whole history, signed for temperature
   localparam int TSUM_W = $clog2(HISTORY_DEPTH * TEMP_MAX + 1) + 1;
   localparam int HSUM_W = $clog2(HISTORY_DEPTH * HUM_MAX + 1);
   localparam int DIV_W  = TSUM_W;
   localparam int DIVCNT_W = $clog2(DIV_W);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_TEMP      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_WIDTH       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_LOW_LIMIT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_HIGH_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOL_MODE        = 3'd4;

   localparam logic [1:0] ALARM_DISABLED = 2'd0;
   localparam logic [1:0] ALARM_ENABLED  = 2'd1;
   localparam logic [1:0] ALARM_ACTIVE   = 2'd2;

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_BUTTON = 1'b1;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   typedef struct packed {
      logic              latch;
      logic              scan_en;
      logic              scan_first;
      logic [SLOT_W-1:0] scan_idx;
      logic              trim;
      logic              div_step;
      logic              mean;
      logic              finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic               item_good;
      logic [COUNT_W-1:0] fill_count;
      logic               out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

// File: design/htc_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencer for the thermostat: accept, history scan, trim, serial divide,
// mean update and result load. Uses htc_pkg types and constants.

module htc_controller (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   output logic                          req_tready,
   input  wire htc_pkg::ctrl_status_type status,
   output htc_pkg::ctrl_cmd_type         cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_TRIM   = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_MEAN   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   logic [htc_pkg::SLOT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [htc_pkg::DIVCNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic                            accept;
   logic                            scan_last;
   logic                            div_last;

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign scan_last  = (htc_pkg::COUNT_W'(scan_idx_ff) + 1'b1) == status.fill_count;
   assign div_last   = (div_cnt_ff == htc_pkg::DIVCNT_W'(htc_pkg::DIV_W - 1));

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      div_cnt_in  = div_cnt_ff;
      cmd         = '0;
      cmd.scan_idx = scan_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            scan_idx_in = '0;
            if (accept) begin
               cmd.latch = 1'b1;
               state_in  = status.item_good ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan_en    = 1'b1;
            cmd.scan_first = (scan_idx_ff == '0);
            if (scan_last) begin
               state_in = ST_TRIM;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_TRIM: begin
            cmd.trim   = 1'b1;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_last) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            cmd.mean = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_idx_ff <= '0;
         div_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         div_cnt_ff  <= div_cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: design/htc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// Thermostat datapath: config registers, sample history, sum/min/max scan,
// restoring divider, hysteresis and alarm logic, result register. Uses htc_pkg.

module htc_datapath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_we,
   input  wire  [htc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [htc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire  [htc_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire                                  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [htc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire  htc_pkg::ctrl_cmd_type          cmd,
   output htc_pkg::ctrl_status_type             status
);

   localparam int TW  = htc_pkg::TEMP_W;
   localparam int HW  = htc_pkg::HUM_W;
   localparam int SW  = htc_pkg::TSUM_W;
   localparam int HSW = htc_pkg::HSUM_W;
   localparam int DW  = htc_pkg::DIV_W;
   localparam int CW  = htc_pkg::COUNT_W;
   localparam int PW  = htc_pkg::SLOT_W;
   localparam int CMP_W = TW + 2;

   function automatic logic [CW+DW-1:0] div_step(input logic [CW-1:0] rem,
                                                 input logic [DW-1:0] quo,
                                                 input logic [CW-1:0] dv);
      logic [CW:0] shifted;
      logic [CW:0] diff;
      logic        ge;
      shifted = {rem, quo[DW-1]};
      diff    = shifted - {1'b0, dv};
      ge      = (shifted >= {1'b0, dv});
      div_step = {(ge ? diff[CW-1:0] : shifted[CW-1:0]), quo[DW-2:0], ge};
   endfunction

   // configuration
   logic signed [TW-1:0] target_ff;
   logic        [TW-1:0] band_ff;
   logic signed [TW-1:0] alarm_low_ff;
   logic signed [TW-1:0] alarm_high_ff;
   logic                 cool_ff;

   // history and item
   logic signed [TW-1:0] temp_hist_ff [htc_pkg::HISTORY_DEPTH];
   logic        [HW-1:0] hum_hist_ff  [htc_pkg::HISTORY_DEPTH];
   logic [PW-1:0]        slot_ff;
   logic [CW-1:0]        fill_ff;
   logic                 is_button_ff;
   logic                 good_ff;

   logic signed [htc_pkg::IN_W-1:0] in_temp;
   logic signed [htc_pkg::IN_W-1:0] in_hum;
   logic                            in_range;
   logic                            item_good;

   // scan accumulators
   logic signed [SW-1:0]  tsum_ff;
   logic signed [TW-1:0]  tmin_ff, tmax_ff;
   logic        [HSW-1:0] hsum_ff;
   logic        [HW-1:0]  hmin_ff, hmax_ff;
   logic signed [TW-1:0]  rd_t;
   logic        [HW-1:0]  rd_h;

   // trim and divide
   logic                  trim_on;
   logic signed [SW-1:0]  t_trim;
   logic        [HSW-1:0] h_trim;
   logic        [DW-1:0]  t_mag;
   logic        [CW-1:0]  divisor;
   logic        [CW-1:0]  divisor_ff;
   logic                  t_neg_ff;
   logic        [DW-1:0]  t_quo_ff, h_quo_ff;
   logic        [CW-1:0]  t_rem_ff, h_rem_ff;
   logic        [CW+DW-1:0] t_next, h_next;

   // control state
   logic signed [TW-1:0] mean_temp_ff;
   logic        [HW-1:0] mean_hum_ff;
   logic drive_req_ff, drive_req_in;
   logic drive_lvl_ff, drive_lvl_in;
   logic alarm_en_ff, alarm_en_in;
   logic alarm_act_ff, alarm_act_in;
   logic buzzer_ff, buzzer_in;
   logic bad_ff, bad_in;

   logic signed [CMP_W-1:0] mt;
   logic signed [CMP_W-1:0] tgt;
   logic signed [CMP_W-1:0] band;
   logic                    alarm_out;
   logic [1:0]              alarm_code;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [htc_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // ---------------- item check ----------------
   assign in_temp  = signed'(req_tdata[15:0]);
   assign in_hum   = signed'(req_tdata[31:16]);
   assign in_range = (in_temp >= htc_pkg::TEMP_MIN) && (in_temp <= htc_pkg::TEMP_MAX) &&
                     (in_hum >= htc_pkg::HUM_MIN) && (in_hum <= htc_pkg::HUM_MAX);
   assign item_good = (req_tuser == htc_pkg::ACTION_SAMPLE) && in_range;

   // item_good, fill_count, out_free
   assign status = {item_good, fill_ff, (!rsp_valid_ff || rsp_tready)};

   // ---------------- config ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= TW'(2000);
         band_ff       <= TW'(50);
         alarm_low_ff  <= TW'(1000);
         alarm_high_ff <= TW'(3000);
         cool_ff       <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            htc_pkg::CSR_TARGET_TEMP:      target_ff     <= signed'(csr_wdata);
            htc_pkg::CSR_BAND_WIDTH:       band_ff       <= csr_wdata;
            htc_pkg::CSR_ALARM_LOW_LIMIT:  alarm_low_ff  <= signed'(csr_wdata);
            htc_pkg::CSR_ALARM_HIGH_LIMIT: alarm_high_ff <= signed'(csr_wdata);
            htc_pkg::CSR_COOL_MODE:        cool_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- history write ----------------
   always_ff @(posedge clock) begin
      if (cmd.latch && item_good) begin
         temp_hist_ff[slot_ff] <= in_temp[TW-1:0];
         hum_hist_ff[slot_ff]  <= in_hum[HW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.latch && item_good) begin
         slot_ff <= (slot_ff == PW'(htc_pkg::HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
         if (fill_ff < CW'(htc_pkg::HISTORY_DEPTH)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         is_button_ff <= (req_tuser == htc_pkg::ACTION_BUTTON);
         good_ff      <= item_good;
      end
   end

   // ---------------- scan ----------------
   assign rd_t = temp_hist_ff[cmd.scan_idx];
   assign rd_h = hum_hist_ff[cmd.scan_idx];

   always_ff @(posedge clock) begin
      if (cmd.scan_en) begin
         if (cmd.scan_first) begin
            tsum_ff <= SW'(rd_t);
            tmin_ff <= rd_t;
            tmax_ff <= rd_t;
            hsum_ff <= HSW'(rd_h);
            hmin_ff <= rd_h;
            hmax_ff <= rd_h;
         end else begin
            tsum_ff <= tsum_ff + SW'(rd_t);
            hsum_ff <= hsum_ff + HSW'(rd_h);
            if (rd_t < tmin_ff) tmin_ff <= rd_t;
            if (rd_t > tmax_ff) tmax_ff <= rd_t;
            if (rd_h < hmin_ff) hmin_ff <= rd_h;
            if (rd_h > hmax_ff) hmax_ff <= rd_h;
         end
      end
   end

   // ---------------- trim and divide ----------------
   assign trim_on = (fill_ff > CW'(2));
   assign t_trim  = trim_on ? (tsum_ff - SW'(tmin_ff) - SW'(tmax_ff)) : tsum_ff;
   assign h_trim  = trim_on ? (hsum_ff - HSW'(hmin_ff) - HSW'(hmax_ff)) : hsum_ff;
   assign t_mag   = t_trim[SW-1] ? DW'(-t_trim) : DW'(t_trim);
   assign divisor = trim_on ? (fill_ff - CW'(2)) : fill_ff;
   assign t_next  = div_step(t_rem_ff, t_quo_ff, divisor_ff);
   assign h_next  = div_step(h_rem_ff, h_quo_ff, divisor_ff);

   always_ff @(posedge clock) begin
      if (cmd.trim) begin
         t_quo_ff   <= t_mag;
         h_quo_ff   <= DW'(h_trim);
         t_rem_ff   <= '0;
         h_rem_ff   <= '0;
         t_neg_ff   <= t_trim[SW-1];
         divisor_ff <= divisor;
      end else if (cmd.div_step) begin
         {t_rem_ff, t_quo_ff} <= t_next;
         {h_rem_ff, h_quo_ff} <= h_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_temp_ff <= '0;
         mean_hum_ff  <= '0;
      end else if (cmd.mean) begin
         mean_temp_ff <= t_neg_ff ? -signed'(t_quo_ff[TW-1:0]) : signed'(t_quo_ff[TW-1:0]);
         mean_hum_ff  <= h_quo_ff[HW-1:0];
      end
   end

   // ---------------- control and alarm ----------------
   assign mt   = CMP_W'(mean_temp_ff);
   assign tgt  = CMP_W'(target_ff);
   assign band = signed'(CMP_W'(band_ff));
   assign alarm_out = (mean_temp_ff > alarm_high_ff) || (mean_temp_ff < alarm_low_ff);

   always_comb begin
      drive_req_in = drive_req_ff;
      drive_lvl_in = drive_lvl_ff;
      alarm_en_in  = alarm_en_ff;
      alarm_act_in = alarm_act_ff;
      buzzer_in    = buzzer_ff;
      bad_in       = bad_ff;
      if (is_button_ff) begin
         if (alarm_en_ff) begin
            alarm_en_in  = 1'b0;
            alarm_act_in = 1'b0;
         end else begin
            alarm_en_in = 1'b1;
         end
         buzzer_in = 1'b0;
      end else if (!good_ff) begin
         bad_in       = 1'b1;
         drive_lvl_in = 1'b0;
         if (alarm_en_ff) begin
            alarm_act_in = 1'b1;
            buzzer_in    = 1'b1;
         end
      end else begin
         bad_in = 1'b0;
         if (drive_req_ff) begin
            if (cool_ff ? (mt <= tgt) : (mt >= tgt)) begin
               drive_req_in = 1'b0;
               drive_lvl_in = 1'b0;
            end
         end else if (cool_ff ? (mt > tgt + band) : (mt < tgt - band)) begin
            drive_req_in = 1'b1;
            drive_lvl_in = 1'b1;
         end
         if (alarm_en_ff) begin
            alarm_act_in = alarm_out;
            buzzer_in    = alarm_out;
         end
      end
   end

   assign alarm_code = alarm_act_in ? htc_pkg::ALARM_ACTIVE :
                       (alarm_en_in ? htc_pkg::ALARM_ENABLED : htc_pkg::ALARM_DISABLED);

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_req_ff <= 1'b0;
         drive_lvl_ff <= 1'b0;
         alarm_en_ff  <= 1'b1;
         alarm_act_ff <= 1'b0;
         buzzer_ff    <= 1'b0;
         bad_ff       <= 1'b0;
      end else if (cmd.finish) begin
         drive_req_ff <= drive_req_in;
         drive_lvl_ff <= drive_lvl_in;
         alarm_en_ff  <= alarm_en_in;
         alarm_act_ff <= alarm_act_in;
         buzzer_ff    <= buzzer_in;
         bad_ff       <= bad_in;
      end
   end

   // ---------------- result register ----------------
   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= {6'd0, mean_hum_ff, mean_temp_ff, bad_in, alarm_code,
                         buzzer_in, drive_lvl_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: design/hysteresis_thermostat_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Hysteresis thermostat controller: on-off heat/cool drive with alarm.
// Input stream (req_): one item per transfer, either a sensor sample or a
// button press (req_tuser). Every accepted item yields exactly one result
// transfer on rsp_ with the drive, buzzer, alarm and held mean values.
// Configuration: csr_we/csr_index/csr_wdata, written while the block is idle.
// Order of work for an in-range sample: the history scan over the entries
// held (1 to 5), the trim, the one-bit-per-cycle restoring divider, the
// mean update and the result load; a button press or an out-of-range
// sample goes straight from acceptance to the result load.
// One item is in flight at a time.
// The result sits in an output register; a new item is accepted while it
// waits, and the next result is held back until rsp_tready takes the
// previous one.
// Reset (synchronous, active high) restores default registers, empties the
// history, enables the alarm and clears drive, buzzer and held means.

module hysteresis_thermostat_controller (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_we,
   input  wire  [htc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [htc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // [15:0] sample_temp, [31:16] sample_humidity
   input  wire  [htc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] action
   input  wire                                req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [0] drive_on, [1] buzzer_on, [3:2] alarm_status, [4] sample_bad,
   // [19:5] mean_temp, [33:20] mean_humidity, [39:34] zero
   output logic [htc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   htc_pkg::ctrl_cmd_type    ctrl_cmd;
   htc_pkg::ctrl_status_type ctrl_status;

   htc_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (ctrl_status),
      .cmd        (ctrl_cmd)
   );

   htc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (ctrl_cmd),
      .status     (ctrl_status)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item is in flight");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.finish |-> ctrl_status.out_free)
      else $error("result loaded over an untaken result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:2] != 2'd3)
      else $error("illegal alarm status code");

   a_buzzer_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[3:2] == htc_pkg::ALARM_ACTIVE)
      else $error("buzzer on without an active alarm");

endmodule

`default_nettype wire
